### rtl/core/boac_pkg.sv
// Package for the bed occupancy alarm controller.
// Holds mode, event and register-index codes plus field widths and reset values.
// No dependencies.
package boac_pkg;

    localparam int LIMIT_W   = 24;
    localparam int SECONDS_W = 16;
    localparam int PASSES_W  = 8;
    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 15;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_SNOOZE = 2'd1,
        MODE_SOUND  = 2'd2,
        MODE_OUTBED = 2'd3
    } mode_t;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SOUND  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SNOOZE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BED_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE_SECS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SECS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OOB_PASSES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_LOW    = 3'd5;

    localparam logic [LIMIT_W-1:0]   BED_LIMIT_RST   = 24'd8800000;
    localparam logic [SECONDS_W-1:0] SNOOZE_SECS_RST = 16'd18;
    localparam logic [SECONDS_W-1:0] CHECK_SECS_RST  = 16'd30;
    localparam logic [PASSES_W-1:0]  OOB_PASSES_RST  = 8'd12;
    localparam logic [PERIOD_W-1:0]  TONE_HIGH_RST   = 16'd120;
    localparam logic [PERIOD_W-1:0]  TONE_LOW_RST    = 16'd50;

endpackage

### rtl/core/bed_occupancy_alarm_controller.sv
// Bed occupancy alarm controller, top level.
// Depends on boac_pkg for codes, widths and register reset values.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transfer: func
//   (tick, sound detected or snooze press) and a raw two's complement
//   load-cell code. The code's top bit is flipped to offset binary and the
//   bed is occupied when that level exceeds bed_limit.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   event: mode, buzzer_on, tone period and duty, and passes done.
//   The state update and the whole result are worked out in the cycle of
//   the input transfer and land in the result register.
//   Throughput: one event per cycle. in_ready is high while the result
//   register is empty or being drained in the same cycle, so a new event
//   follows straight on; a stalled receiver holds the result and blocks
//   the input until it is taken.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once;
//   indexes beyond the list are ignored. Write only while idle.
//   Reset (rst_n low, asynchronous): mode waiting for sound, all counters
//   and tone select cleared, registers back to their defaults, no result.
module bed_occupancy_alarm_controller #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [boac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [boac_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [boac_pkg::FUNC_W-1:0]       func,
    input  logic [SAMPLE_BITS-1:0]            load_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        mode,
    output logic                              buzzer_on,
    output logic [boac_pkg::PERIOD_W-1:0]     tone_period,
    output logic [boac_pkg::DUTY_W-1:0]       tone_duty,
    output logic [boac_pkg::PASSES_W-1:0]     passes_done
);
    import boac_pkg::*;

    // Compare width covers both the sample and the limit.
    localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

    // Configuration registers
    logic [LIMIT_W-1:0]   bed_limit_reg;
    logic [SECONDS_W-1:0] snooze_secs_reg;
    logic [SECONDS_W-1:0] check_secs_reg;
    logic [PASSES_W-1:0]  oob_passes_reg;
    logic [PERIOD_W-1:0]  tone_high_reg;
    logic [PERIOD_W-1:0]  tone_low_reg;

    // Controller state
    mode_t                mode_reg, mode_next;
    logic [SECONDS_W-1:0] tick_reg, tick_next;
    logic [SECONDS_W-1:0] target_reg, target_next;
    logic [PASSES_W-1:0]  pass_reg, pass_next;
    logic                 tsel_reg, tsel_next;

    // Result register
    logic                 out_valid_reg;
    mode_t                res_mode_reg;
    logic [PERIOD_W-1:0]  res_period_reg, period_next;
    logic [PASSES_W-1:0]  res_pass_reg;

    logic                 in_fire;
    logic [SAMPLE_BITS-1:0] level;
    logic                 occupied;
    logic                 expired;
    logic [PASSES_W-1:0]  pass_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Offset binary: flip the sign bit.
    assign level    = load_sample ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign occupied = CMP_W'(level) > CMP_W'(bed_limit_reg);
    assign expired  = (tick_reg == target_reg);
    assign pass_inc = pass_reg + PASSES_W'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        tick_next   = tick_reg;
        target_next = target_reg;
        pass_next   = pass_reg;
        tsel_next   = tsel_reg;
        case (func)
            FUNC_SOUND:
            begin
                if (mode_reg == MODE_WAIT)
                begin
                    tick_next = '0;
                    if (occupied)
                    begin
                        mode_next   = MODE_SNOOZE;
                        target_next = snooze_secs_reg;
                    end
                    else
                    begin
                        pass_next   = '0;
                        mode_next   = MODE_OUTBED;
                        target_next = check_secs_reg;
                    end
                end
            end
            FUNC_SNOOZE:
            begin
                // Snooze only counts while sounding.
                if (mode_reg == MODE_SOUND)
                begin
                    mode_next   = MODE_SNOOZE;
                    target_next = snooze_secs_reg;
                    tick_next   = '0;
                end
            end
            FUNC_TICK:
            begin
                if (mode_reg != MODE_WAIT)
                begin
                    tick_next = tick_reg + SECONDS_W'(1);
                end
                case (mode_reg)
                    MODE_SOUND:
                    begin
                        tsel_next = !tsel_reg;
                    end
                    MODE_SNOOZE:
                    begin
                        if (expired)
                        begin
                            if (occupied)
                            begin
                                mode_next = MODE_SOUND;
                            end
                            else
                            begin
                                pass_next   = '0;
                                mode_next   = MODE_OUTBED;
                                target_next = check_secs_reg;
                                tick_next   = '0;
                            end
                        end
                    end
                    MODE_OUTBED:
                    begin
                        if (expired)
                        begin
                            pass_next = pass_inc;
                            if (pass_inc == oob_passes_reg)
                            begin
                                mode_next = MODE_WAIT;
                            end
                            else if (occupied)
                            begin
                                pass_next = '0;
                                mode_next = MODE_SOUND;
                            end
                            else
                            begin
                                target_next = check_secs_reg;
                                tick_next   = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // waiting: ticks ignored
                    end
                endcase
            end
            default:
            begin
                // unused code: state unchanged
            end
        endcase
        period_next = tsel_next ? tone_low_reg : tone_high_reg;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bed_limit_reg   <= BED_LIMIT_RST;
            snooze_secs_reg <= SNOOZE_SECS_RST;
            check_secs_reg  <= CHECK_SECS_RST;
            oob_passes_reg  <= OOB_PASSES_RST;
            tone_high_reg   <= TONE_HIGH_RST;
            tone_low_reg    <= TONE_LOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BED_LIMIT:   bed_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_SNOOZE_SECS: snooze_secs_reg <= cfg_data[SECONDS_W-1:0];
                CFG_CHECK_SECS:  check_secs_reg  <= cfg_data[SECONDS_W-1:0];
                CFG_OOB_PASSES:  oob_passes_reg  <= cfg_data[PASSES_W-1:0];
                CFG_TONE_HIGH:   tone_high_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_TONE_LOW:    tone_low_reg    <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // State and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAIT;
            tick_reg      <= '0;
            target_reg    <= '0;
            pass_reg      <= '0;
            tsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg      <= mode_next;
                tick_reg      <= tick_next;
                target_reg    <= target_next;
                pass_reg      <= pass_next;
                tsel_reg      <= tsel_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_mode_reg   <= mode_next;
            res_period_reg <= period_next;
            res_pass_reg   <= pass_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = res_mode_reg;
    assign buzzer_on   = (res_mode_reg == MODE_SOUND);
    assign tone_period = res_period_reg;
    assign tone_duty   = res_period_reg[PERIOD_W-1:1];
    assign passes_done = res_pass_reg;

`ifndef SYNTHESIS
    // A blocked input only ever comes from a held result.
    a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input blocked without a stalled result");

    // A tick while waiting leaves the block waiting.
    a_tick_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == FUNC_TICK && mode_reg == MODE_WAIT) |=> (mode_reg == MODE_WAIT))
        else $error("tick moved the block out of waiting");

    // Reported mode follows the state after each transfer.
    a_result_mode: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (res_mode_reg == mode_reg && res_pass_reg == pass_reg))
        else $error("result does not match updated state");
`endif

endmodule
